// ----- hdl/spmf_pkg.sv -----
// Package for the strict-priority multi-FIFO: field widths, operation and
// status codes, and the control state type.
// No dependencies.
`default_nettype none

package spmf_pkg;

  localparam int MODE_W   = 2;
  localparam int PRI_W    = 3;
  localparam int TASK_W   = 32;
  localparam int STATUS_W = 2;
  localparam int LCOUNT_W = 5;
  localparam int TCOUNT_W = 8;
  localparam int CFG_W    = 4;

  localparam logic [CFG_W-1:0] LEVELS_RESET = 4'd8;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_PEEK   = 2'd2,
    MODE_NOP    = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PTR,
    ST_DATA,
    ST_CNT,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// ----- hdl/spmf_if.sv -----
// Valid/ready channel interfaces for the strict-priority multi-FIFO:
// the operation request channel and the result channel.
// Depends on spmf_pkg.
`default_nettype none

interface spmf_op_if;
  import spmf_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [PRI_W-1:0]  priority_req;
  logic [TASK_W-1:0] task_id;

  modport source (output valid, mode, priority_req, task_id, input ready);
  modport sink   (input valid, mode, priority_req, task_id, output ready);
endinterface

interface spmf_res_if;
  import spmf_pkg::*;

  logic                valid;
  logic                ready;
  logic [TASK_W-1:0]   head_task_id;
  logic [PRI_W-1:0]    head_priority;
  logic [STATUS_W-1:0] status;
  logic [LCOUNT_W-1:0] level_count;
  logic [TCOUNT_W-1:0] total_count;
  logic                all_empty;

  modport source (output valid, head_task_id, head_priority, status, level_count,
                  total_count, all_empty, input ready);
  modport sink   (input valid, head_task_id, head_priority, status, level_count,
                  total_count, all_empty, output ready);
endinterface

`default_nettype wire

// ----- hdl/spmf_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
`default_nettype none

module spmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/strict_priority_multi_fifo.sv -----
// Top level of the strict-priority multi-FIFO: control sequencer, pointer
// and entry memories. Depends on spmf_pkg, spmf_if and spmf_ram.
//
//   Channel    Dir  Handshake      Payload
//   op_i       in   valid/ready    mode, priority_req, task_id
//   res_o      out  valid/ready    head_task_id, head_priority, status,
//                                  level_count, total_count, all_empty
//   cfg        in   cfg_we_i       cfg_wdata_i (levels_in_use)
//
// One transaction is handled at a time. Insert, no-op and remove/peek on an
// empty queue pass through the states PTR and DONE before the result is
// loaded into the output register; a remove or peek that finds an entry
// passes through PTR, DATA, CNT and DONE. The next request is taken only
// back in IDLE. The pointer memory's single read port, used once for the
// head level and once more for the requested level's count, is why that
// path needs the extra DATA and CNT states.
// The output register lets a new transaction be accepted while a result
// waits; a result that cannot be loaded holds the sequencer in its last state.
// Reset clears the per-level written and non-empty flags, the total count and
// the register; there is no clearing pass.
`default_nettype none

module strict_priority_multi_fifo #(
  parameter int NUM_LEVELS  = 8,
  parameter int LEVEL_DEPTH = 16,
  parameter int ID_BITS     = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  spmf_op_if.sink                         op_i,
  spmf_res_if.source                      res_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [spmf_pkg::CFG_W-1:0] cfg_wdata_i
);
  import spmf_pkg::*;

  localparam int LVL_W  = $clog2(NUM_LEVELS);
  localparam int PTR_W  = $clog2(LEVEL_DEPTH);
  localparam int FILL_W = $clog2(LEVEL_DEPTH + 1);
  localparam int TOT_W  = $clog2(NUM_LEVELS * LEVEL_DEPTH + 1);
  localparam int ENT_N  = NUM_LEVELS * LEVEL_DEPTH;
  localparam int ENT_AW = $clog2(ENT_N);

  // Per-level ring state, one word of the pointer memory.
  typedef struct packed {
    logic [PTR_W-1:0]  head;
    logic [PTR_W-1:0]  tail;
    logic [FILL_W-1:0] fill;
  } ptr_t;

  localparam int PTR_BITS = $bits(ptr_t);

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  function automatic logic [ENT_AW-1:0] ent_addr(input logic [LVL_W-1:0] lvl,
                                                  input logic [PTR_W-1:0] p);
    logic [ENT_AW-1:0] a;
    a = ENT_AW'(lvl) * ENT_AW'(LEVEL_DEPTH) + ENT_AW'(p);
    return a;
  endfunction

  // Control and bookkeeping registers.
  state_e                state_q, state_d;
  mode_e                 op_q, op_d;
  logic [PRI_W-1:0]      req_q, req_d;
  logic [ID_BITS-1:0]    id_q, id_d;
  logic [LVL_W-1:0]      sel_q, sel_d;
  logic                  found_q, found_d;
  logic                  ptr_vld_q, ptr_vld_d;
  logic [CFG_W-1:0]      levels_in_use_q;
  logic [NUM_LEVELS-1:0] nonempty_q, nonempty_d;
  logic [NUM_LEVELS-1:0] written_q, written_d;
  logic [TOT_W-1:0]      total_q, total_d;
  logic [ID_BITS-1:0]    res_id_q, res_id_d;
  status_e               res_status_q, res_status_d;
  logic [FILL_W-1:0]     res_count_q, res_count_d;

  // Output register.
  logic                  out_valid_q;
  logic [TASK_W-1:0]     out_id_q;
  logic [PRI_W-1:0]      out_pri_q;
  status_e               out_status_q;
  logic [LCOUNT_W-1:0]   out_count_q;
  logic [TCOUNT_W-1:0]   out_total_q;
  logic                  out_empty_q;
  logic                  load_out;

  // Memory ports.
  logic                  ptr_we, ptr_re;
  logic [LVL_W-1:0]      ptr_waddr, ptr_raddr;
  ptr_t                  ptr_wdata;
  logic [PTR_BITS-1:0]   ptr_rdata;
  ptr_t                  ptr_rd;
  logic                  ent_we, ent_re;
  logic [ENT_AW-1:0]     ent_waddr, ent_raddr;
  logic [ID_BITS-1:0]    ent_rdata;

  // Combinational helpers.
  logic [CFG_W-1:0]      lvl_lim;
  logic                  req_en;
  logic [LVL_W-1:0]      req_lvl;
  logic                  scan_found;
  logic [LVL_W-1:0]      scan_sel;
  logic [LVL_W-1:0]      in_lvl;
  mode_e                 in_mode;

  spmf_ram #(
    .WIDTH (PTR_BITS),
    .DEPTH (NUM_LEVELS)
  ) u_ptr_ram (
    .clk_i   (clk_i),
    .we_i    (ptr_we),
    .waddr_i (ptr_waddr),
    .wdata_i (ptr_wdata),
    .re_i    (ptr_re),
    .raddr_i (ptr_raddr),
    .rdata_o (ptr_rdata)
  );

  spmf_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (ENT_N)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (id_q),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  // A level that was never written reads as pointers of zero.
  assign ptr_rd = ptr_vld_q ? ptr_t'(ptr_rdata) : '0;

  // Effective level count is the register clipped to the levels built.
  assign lvl_lim = (32'(levels_in_use_q) > NUM_LEVELS) ? CFG_W'(NUM_LEVELS)
                                                       : levels_in_use_q;
  assign req_en  = ({1'b0, req_q} < lvl_lim);
  assign req_lvl = LVL_W'(req_q);
  assign in_mode = mode_e'(op_i.mode);

  // Priority encoder over the enabled, non-empty levels: lowest index wins.
  always_comb begin
    scan_found = 1'b0;
    scan_sel   = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (!scan_found && nonempty_q[i] && (i < int'(lvl_lim))) begin
        scan_found = 1'b1;
        scan_sel   = LVL_W'(i);
      end
    end
  end

  // Remove and peek that find an entry read the head level's pointers first;
  // everything else reads the requested level.
  assign in_lvl = ((in_mode == MODE_REMOVE || in_mode == MODE_PEEK) && scan_found)
                  ? scan_sel : LVL_W'(op_i.priority_req);

  assign op_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    req_d        = req_q;
    id_d         = id_q;
    sel_d        = sel_q;
    found_d      = found_q;
    ptr_vld_d    = ptr_vld_q;
    nonempty_d   = nonempty_q;
    written_d    = written_q;
    total_d      = total_q;
    res_id_d     = res_id_q;
    res_status_d = res_status_q;
    res_count_d  = res_count_q;
    ptr_we       = 1'b0;
    ptr_waddr    = req_lvl;
    ptr_wdata    = ptr_rd;
    ptr_re       = 1'b0;
    ptr_raddr    = req_lvl;
    ent_we       = 1'b0;
    ent_waddr    = ent_addr(req_lvl, ptr_rd.tail);
    ent_re       = 1'b0;
    ent_raddr    = ent_addr(sel_q, ptr_rd.head);
    load_out     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (op_i.valid) begin
          op_d         = in_mode;
          req_d        = op_i.priority_req;
          id_d         = ID_BITS'(op_i.task_id);
          sel_d        = scan_sel;
          found_d      = scan_found;
          res_id_d     = '0;
          res_status_d = STAT_OK;
          res_count_d  = '0;
          ptr_re       = 1'b1;
          ptr_raddr    = in_lvl;
          ptr_vld_d    = written_q[in_lvl];
          state_d      = ST_PTR;
        end
      end

      ST_PTR: begin
        state_d = ST_DONE;
        case (op_q) inside
          MODE_INSERT: begin
            if (!req_en) begin
              res_status_d = STAT_RANGE;
            end else if (ptr_rd.fill == FILL_W'(LEVEL_DEPTH)) begin
              res_status_d = STAT_FULL;
              res_count_d  = ptr_rd.fill;
            end else begin
              ent_we              = 1'b1;
              ptr_we              = 1'b1;
              ptr_wdata.tail      = ring_next(ptr_rd.tail);
              ptr_wdata.fill      = ptr_rd.fill + 1'b1;
              written_d[req_lvl]  = 1'b1;
              nonempty_d[req_lvl] = 1'b1;
              total_d             = total_q + 1'b1;
              res_count_d         = ptr_rd.fill + 1'b1;
            end
          end
          MODE_REMOVE, MODE_PEEK: begin
            if (!found_q) begin
              res_status_d = STAT_EMPTY;
              res_count_d  = req_en ? ptr_rd.fill : '0;
            end else begin
              ent_re = 1'b1;
              if (op_q == MODE_REMOVE) begin
                ptr_we            = 1'b1;
                ptr_waddr         = sel_q;
                ptr_wdata.head    = ring_next(ptr_rd.head);
                ptr_wdata.fill    = ptr_rd.fill - 1'b1;
                nonempty_d[sel_q] = (ptr_rd.fill != FILL_W'(1));
                total_d           = total_q - 1'b1;
              end
              state_d = ST_DATA;
            end
          end
          default: begin
            res_count_d = req_en ? ptr_rd.fill : '0;
          end
        endcase
      end

      ST_DATA: begin
        // Head entry arrives; fetch the requested level's count, which the
        // write-back of the previous cycle has already updated.
        res_id_d  = ent_rdata;
        ptr_re    = 1'b1;
        ptr_raddr = req_lvl;
        ptr_vld_d = written_q[req_lvl];
        state_d   = ST_CNT;
      end

      ST_CNT: begin
        res_count_d = req_en ? ptr_rd.fill : '0;
        state_d     = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || res_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      nonempty_q      <= '0;
      written_q       <= '0;
      total_q         <= '0;
      levels_in_use_q <= LEVELS_RESET;
      out_valid_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      nonempty_q <= nonempty_d;
      written_q  <= written_d;
      total_q    <= total_d;
      if (cfg_we_i) begin
        levels_in_use_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    req_q        <= req_d;
    id_q         <= id_d;
    sel_q        <= sel_d;
    found_q      <= found_d;
    ptr_vld_q    <= ptr_vld_d;
    res_id_q     <= res_id_d;
    res_status_q <= res_status_d;
    res_count_q  <= res_count_d;
    if (load_out) begin
      out_id_q     <= TASK_W'(res_id_q);
      out_pri_q    <= (found_q && (op_q == MODE_REMOVE || op_q == MODE_PEEK))
                      ? PRI_W'(sel_q) : '0;
      out_status_q <= res_status_q;
      out_count_q  <= LCOUNT_W'(res_count_q);
      out_total_q  <= TCOUNT_W'(total_q);
      out_empty_q  <= (total_q == '0);
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.head_task_id  = out_id_q;
  assign res_o.head_priority = out_pri_q;
  assign res_o.status        = out_status_q;
  assign res_o.level_count   = out_count_q;
  assign res_o.total_count   = out_total_q;
  assign res_o.all_empty     = out_empty_q;

endmodule

`default_nettype wire

// ----- hdl/spmf_checker.sv -----
// Port-level assertions for the strict-priority multi-FIFO and the bind that
// attaches them to the top level. Depends on spmf_pkg and the top level.
`default_nettype none

module spmf_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_i,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic [spmf_pkg::TASK_W-1:0]   head_task_id_i,
  input wire logic [spmf_pkg::PRI_W-1:0]    head_priority_i,
  input wire logic [spmf_pkg::STATUS_W-1:0] status_i,
  input wire logic [spmf_pkg::LCOUNT_W-1:0] level_count_i,
  input wire logic [spmf_pkg::TCOUNT_W-1:0] total_count_i,
  input wire logic                          all_empty_i
);
  import spmf_pkg::*;

  // A result that is not taken stays offered unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(head_task_id_i) &&
      $stable(status_i) && $stable(level_count_i) && $stable(total_count_i))
    else $error("result changed while stalled");

  // Only one transaction is in work at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request accepted while busy");

  // The empty flag is set only when the total is zero.
  a_empty_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && all_empty_i |-> total_count_i == '0)
    else $error("all_empty set with entries held");

  // Rejected inserts return no head entry.
  a_reject_no_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == STAT_RANGE || status_i == STAT_FULL) |->
      head_task_id_i == '0 && head_priority_i == '0)
    else $error("rejected insert returned a head entry");

endmodule

bind strict_priority_multi_fifo spmf_checker u_spmf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (op_i.valid),
  .in_ready_i      (op_i.ready),
  .out_valid_i     (res_o.valid),
  .out_ready_i     (res_o.ready),
  .head_task_id_i  (res_o.head_task_id),
  .head_priority_i (res_o.head_priority),
  .status_i        (res_o.status),
  .level_count_i   (res_o.level_count),
  .total_count_i   (res_o.total_count),
  .all_empty_i     (res_o.all_empty)
);

`default_nettype wire
